// ===== rtl/dli_pkg.sv =====
// Shared constants and types for the two-axis DDA line interpolator.
`timescale 1ns / 1ps

package dli_pkg;

  // Default coordinate width of the line interpolator.
  localparam int COORD_BITS_DEF = 15;

  // Modulus exponent used after reset and when the larger delta is below two.
  localparam int DEFAULT_MOD_EXP = 3;

  // Operation code carried by each command word.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } dli_op_t;

  // Per-axis update controls driven by the top level.
  typedef struct packed {
    logic update;
    logic load;
  } dli_axis_ctrl_t;

endpackage

// ===== rtl/dli_cmd_if.sv =====
// Command channel: operation plus start and end points.
`timescale 1ns / 1ps

interface dli_cmd_if #(
  parameter int COORD_BITS = dli_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;

  modport source (
    output valid, operation, start_x, start_y, end_x, end_y,
    input  ready
  );

  modport sink (
    input  valid, operation, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

// ===== rtl/dli_res_if.sv =====
// Result channel: position, step flags, directions and done flag.
`timescale 1ns / 1ps

interface dli_res_if #(
  parameter int COORD_BITS = dli_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic                  step_x;
  logic                  step_y;
  logic                  dir_x;
  logic                  dir_y;
  logic                  done_res;

  modport source (
    output valid, pos_x, pos_y, step_x, step_y, dir_x, dir_y, done_res,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, step_x, step_y, dir_x, dir_y, done_res,
    output ready
  );
endinterface

// ===== rtl/dda_line_interpolator_top.sv =====
// Top level of the two-axis DDA line interpolator.
// Usage:
//   Commands arrive on the cmd channel, results leave on the res channel,
//   both valid/ready handshakes that move one word per accepted edge.
//   A load word (operation 0) latches a line from start to end and returns
//   the start point with both step flags low. A tick word (operation 1)
//   advances each axis accumulator that has steps left and reports the
//   new position, the step flags, the directions and done_res.
//   A command accepted by the handshake is registered in the input stage
//   and moves into the result register once that register is free or
//   draining. One word per cycle while the receiver takes results; each
//   tick is one add and one compare against a power-of-two modulus per
//   axis.
//   Every command gives exactly one result.
//   Reset (rst, synchronous) empties both stages and clears the line state,
//   so the block reports done until the first load.
//   When the receiver stalls, the result register holds its word and the
//   input stage holds one more command; cmd.ready then drops.
`timescale 1ns / 1ps

module dda_line_interpolator_top #(
  parameter int COORD_BITS = dli_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  dli_cmd_if.sink   cmd,
  dli_res_if.source res
);

  localparam int EXP_BITS = $clog2(COORD_BITS + 1);

  // Input stage.
  logic                  s1_valid;
  logic                  s1_op;
  logic [COORD_BITS-1:0] s1_start_x;
  logic [COORD_BITS-1:0] s1_start_y;
  logic [COORD_BITS-1:0] s1_end_x;
  logic [COORD_BITS-1:0] s1_end_y;
  logic                  s1_go;

  // Modulus exponent of the current line.
  logic [EXP_BITS-1:0]   mod_exp;
  logic [EXP_BITS-1:0]   mod_exp_next;
  logic [COORD_BITS:0]   modulus;
  logic [COORD_BITS:0]   load_modulus;
  logic [COORD_BITS-1:0] load_delta_x;
  logic [COORD_BITS-1:0] load_delta_y;
  logic [COORD_BITS-1:0] big_delta;

  dli_pkg::dli_axis_ctrl_t axis_ctrl;

  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic                  step_x_next;
  logic                  step_y_next;
  logic                  dir_x_next;
  logic                  dir_y_next;
  logic                  done_x_next;
  logic                  done_y_next;

  // The input stage moves on when the result register is free or draining.
  assign s1_go     = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_op      <= cmd.operation;
      s1_start_x <= cmd.start_x;
      s1_start_y <= cmd.start_y;
      s1_end_x   <= cmd.end_x;
      s1_end_y   <= cmd.end_y;
    end
  end

  assign axis_ctrl.update = s1_go;
  assign axis_ctrl.load   = (s1_op == dli_pkg::OP_LOAD);

  // Modulus is twice the highest set bit above bit zero of the larger delta.
  assign big_delta = (load_delta_x > load_delta_y) ? load_delta_x : load_delta_y;

  always_comb begin
    mod_exp_next = EXP_BITS'(dli_pkg::DEFAULT_MOD_EXP);
    for (int b = 1; b < COORD_BITS; b++) begin
      if (big_delta[b]) begin
        mod_exp_next = EXP_BITS'(b + 1);
      end
    end
  end

  assign modulus      = (COORD_BITS + 1)'(1) << mod_exp;
  assign load_modulus = (COORD_BITS + 1)'(1) << mod_exp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_exp <= EXP_BITS'(dli_pkg::DEFAULT_MOD_EXP);
    end else if (s1_go && axis_ctrl.load) begin
      mod_exp <= mod_exp_next;
    end
  end

  // Two identical axes.
  dli_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (axis_ctrl),
    .start_pt     (s1_start_x),
    .end_pt       (s1_end_x),
    .modulus      (modulus),
    .load_modulus (load_modulus),
    .load_delta   (load_delta_x),
    .pos_next     (pos_x_next),
    .step         (step_x_next),
    .dir_next     (dir_x_next),
    .done_next    (done_x_next)
  );

  dli_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (axis_ctrl),
    .start_pt     (s1_start_y),
    .end_pt       (s1_end_y),
    .modulus      (modulus),
    .load_modulus (load_modulus),
    .load_delta   (load_delta_y),
    .pos_next     (pos_y_next),
    .step         (step_y_next),
    .dir_next     (dir_y_next),
    .done_next    (done_y_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_go) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      res.pos_x    <= pos_x_next;
      res.pos_y    <= pos_y_next;
      res.step_x   <= step_x_next;
      res.step_y   <= step_y_next;
      res.dir_x    <= dir_x_next;
      res.dir_y    <= dir_y_next;
      res.done_res <= done_x_next && done_y_next;
    end
  end

endmodule

// ===== rtl/dli_axis.sv =====
// One DDA axis: delta, direction, remainder, step count and position.
`timescale 1ns / 1ps

module dli_axis #(
  parameter int COORD_BITS = dli_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dli_pkg::dli_axis_ctrl_t ctrl,
  input  logic [COORD_BITS-1:0] start_pt,
  input  logic [COORD_BITS-1:0] end_pt,
  input  logic [COORD_BITS:0]   modulus,
  input  logic [COORD_BITS:0]   load_modulus,
  output logic [COORD_BITS-1:0] load_delta,
  output logic [COORD_BITS-1:0] pos_next,
  output logic                  step,
  output logic                  dir_next,
  output logic                  done_next
);

  logic [COORD_BITS-1:0] pos;
  logic [COORD_BITS-1:0] delta;
  logic                  dir;
  logic [COORD_BITS:0]   rem;
  logic [COORD_BITS-1:0] cnt;

  logic [COORD_BITS-1:0] delta_next;
  logic [COORD_BITS:0]   rem_next;
  logic [COORD_BITS-1:0] cnt_next;
  logic                  load_dir;
  logic [COORD_BITS:0]   sum;

  // Direction and absolute distance of a newly loaded line.
  assign load_dir   = end_pt > start_pt;
  assign load_delta = load_dir ? (end_pt - start_pt) : (start_pt - end_pt);

  // Accumulate while steps remain; the sum stays below twice the modulus.
  assign sum = rem + {1'b0, delta};

  always_comb begin
    pos_next   = pos;
    delta_next = delta;
    dir_next   = dir;
    rem_next   = rem;
    cnt_next   = cnt;
    step       = 1'b0;
    if (ctrl.load) begin
      pos_next   = start_pt;
      delta_next = load_delta;
      dir_next   = load_dir;
      rem_next   = load_modulus >> 1;
      cnt_next   = '0;
    end else if (cnt < delta) begin
      if (sum >= modulus) begin
        rem_next = sum - modulus;
        cnt_next = cnt + 1'b1;
        pos_next = dir ? (pos + 1'b1) : (pos - 1'b1);
        step     = 1'b1;
      end else begin
        rem_next = sum;
      end
    end
  end

  assign done_next = (cnt_next == delta_next);

  // Axis state follows each word that leaves the input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      delta <= '0;
      dir   <= 1'b0;
      rem   <= '0;
      cnt   <= '0;
    end else if (ctrl.update) begin
      pos   <= pos_next;
      delta <= delta_next;
      dir   <= dir_next;
      rem   <= rem_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== rtl/dli_checker.sv =====
// Port-level checks for the DDA line interpolator, bound to the top level.
`timescale 1ns / 1ps

module dli_checker #(
  parameter int COORD_BITS = dli_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [COORD_BITS-1:0] res_pos_x,
  input logic [COORD_BITS-1:0] res_pos_y,
  input logic                  res_step_x,
  input logic                  res_step_y,
  input logic                  res_done_res
);

  // A reset leaves no result word pending.
  a_reset_empties: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // With the result register empty the input stage can always move on.
  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> cmd_ready)
    else $error("command not accepted while result register empty");

  // A stalled result word keeps its position, step flags and done flag.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_pos_x)
      && $stable(res_pos_y) && $stable(res_step_x) && $stable(res_step_y)
      && $stable(res_done_res))
    else $error("stalled result word changed");

endmodule

bind dda_line_interpolator_top dli_checker #(.COORD_BITS(COORD_BITS)) u_dli_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_pos_x    (res.pos_x),
  .res_pos_y    (res.pos_y),
  .res_step_x   (res.step_x),
  .res_step_y   (res.step_y),
  .res_done_res (res.done_res)
);

// ===== tb/sv/tb_dda_line_interpolator_top.sv =====
// Self-checking testbench for the two-axis DDA line interpolator top level.
`timescale 1ns / 1ps

module tb_dda_line_interpolator_top;

  localparam int CB = dli_pkg::COORD_BITS_DEF;
  localparam int CMAX = (1 << CB) - 1;
  localparam int RANDOM_WORDS = 800;

  typedef logic [CB-1:0] coord_t;

  typedef struct packed {
    dli_pkg::dli_op_t op;
    coord_t           start_x;
    coord_t           start_y;
    coord_t           end_x;
    coord_t           end_y;
  } cmd_word_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    logic   step_x;
    logic   step_y;
    logic   dir_x;
    logic   dir_y;
    logic   done;
  } move_word_t;

  // One directed command, with its outcome typed in where it is obvious.
  typedef struct {
    cmd_word_t  cmd;
    bit         typed;
    move_word_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;

  dli_cmd_if #(.COORD_BITS(CB)) cmd_ch ();
  dli_res_if #(.COORD_BITS(CB)) res_ch ();

  dda_line_interpolator_top #(.COORD_BITS(CB)) uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the line state; index 0 is the x axis, 1 the y axis.
  coord_t      line_pos   [2];
  coord_t      line_delta [2];
  logic        line_dir   [2];
  logic [CB:0] line_rem   [2];
  coord_t      line_cnt   [2];
  logic [4:0]  line_mexp;

  move_word_t expected_moves [$];
  plan_row_t  plan [$];

  int unsigned mismatches = 0;
  int unsigned loads_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned words_sent = 0;
  int unsigned moves_checked = 0;
  int unsigned steps_seen = 0;
  int unsigned finishes_seen = 0;
  bit          no_gaps = 1'b0;

  // Modulus exponent: one above the highest set bit among bits 1 and up.
  function automatic logic [4:0] modulus_exp_for(input coord_t big);
    logic [4:0] e;
    e = 5'(dli_pkg::DEFAULT_MOD_EXP);
    for (int b = 1; b < CB; b++) begin
      if (big[b]) e = 5'(b + 1);
    end
    return e;
  endfunction

  // Advance the shadow line state by one command word and return its outcome.
  function automatic move_word_t interpolate_word(input cmd_word_t w);
    move_word_t    r;
    coord_t        from [2];
    coord_t        to [2];
    logic          stepped [2];
    logic [CB+1:0] sum;
    logic [CB:0]   modulus;
    from[0] = w.start_x;
    from[1] = w.start_y;
    to[0] = w.end_x;
    to[1] = w.end_y;
    stepped[0] = 1'b0;
    stepped[1] = 1'b0;
    if (w.op == dli_pkg::OP_LOAD) begin
      for (int a = 0; a < 2; a++) begin
        line_dir[a] = to[a] > from[a];
        line_delta[a] = line_dir[a] ? coord_t'(to[a] - from[a]) : coord_t'(from[a] - to[a]);
        line_cnt[a] = '0;
        line_pos[a] = from[a];
      end
      line_mexp = modulus_exp_for(line_delta[0] > line_delta[1] ? line_delta[0]
                                                                : line_delta[1]);
      for (int a = 0; a < 2; a++) begin
        line_rem[a] = (CB+1)'(1) << (line_mexp - 5'd1);
      end
    end else begin
      modulus = (CB+1)'(1) << line_mexp;
      for (int a = 0; a < 2; a++) begin
        if (line_cnt[a] < line_delta[a]) begin
          sum = line_rem[a] + line_delta[a];
          line_rem[a] = sum[CB:0];
          if (line_rem[a] >= modulus) begin
            line_rem[a] = line_rem[a] - modulus;
            line_cnt[a] = line_cnt[a] + 1'b1;
            line_pos[a] = line_dir[a] ? coord_t'(line_pos[a] + 1'b1)
                                      : coord_t'(line_pos[a] - 1'b1);
            stepped[a] = 1'b1;
          end
        end
      end
    end
    r.pos_x = line_pos[0];
    r.pos_y = line_pos[1];
    r.step_x = stepped[0];
    r.step_y = stepped[1];
    r.dir_x = line_dir[0];
    r.dir_y = line_dir[1];
    r.done = (line_cnt[0] == line_delta[0]) && (line_cnt[1] == line_delta[1]);
    return r;
  endfunction

  function automatic cmd_word_t cmd_of(input dli_pkg::dli_op_t op, input int sx,
                                       input int sy, input int ex, input int ey);
    cmd_word_t w;
    w.op = op;
    w.start_x = coord_t'(sx);
    w.start_y = coord_t'(sy);
    w.end_x = coord_t'(ex);
    w.end_y = coord_t'(ey);
    return w;
  endfunction

  function automatic move_word_t move_of(input int px, input int py, input bit sx,
                                         input bit sy, input bit dx, input bit dy,
                                         input bit dn);
    move_word_t m;
    m.pos_x = coord_t'(px);
    m.pos_y = coord_t'(py);
    m.step_x = sx;
    m.step_y = sy;
    m.dir_x = dx;
    m.dir_y = dy;
    m.done = dn;
    return m;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A coordinate near c, clipped to the field range.
  function automatic coord_t near_coord(input coord_t c, input int span);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > CMAX) v = CMAX;
    return coord_t'(v);
  endfunction

  // Offer one word, wait for the handshake, record its outcome, then idle.
  task automatic send_word(input cmd_word_t w, input bit typed, input move_word_t want);
    move_word_t predicted;
    int unsigned gap;
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= w.op;
    cmd_ch.start_x <= w.start_x;
    cmd_ch.start_y <= w.start_y;
    cmd_ch.end_x <= w.end_x;
    cmd_ch.end_y <= w.end_y;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = interpolate_word(w);
    expected_moves.push_back(typed ? want : predicted);
    words_sent++;
    if (w.op == dli_pkg::OP_LOAD) loads_sent++;
    else ticks_sent++;
    gap = idle_span();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_moves();
    while (expected_moves.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Result side: randomly stalled ready.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      if (idle_span() != 0) begin
        res_ch.ready <= 1'b0;
        repeat (idle_span() + 1) @(posedge clk);
      end
    end
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    move_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_moves.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, actual pos %0d,%0d step %0b%0b dir %0b%0b done %0b",
                 $time, res_ch.pos_x, res_ch.pos_y, res_ch.step_x, res_ch.step_y,
                 res_ch.dir_x, res_ch.dir_y, res_ch.done_res);
      end else begin
        want = expected_moves.pop_front();
        check_field("pos_x", want.pos_x, res_ch.pos_x);
        check_field("pos_y", want.pos_y, res_ch.pos_y);
        check_field("step_x", want.step_x, res_ch.step_x);
        check_field("step_y", want.step_y, res_ch.step_y);
        check_field("dir_x", want.dir_x, res_ch.dir_x);
        check_field("dir_y", want.dir_y, res_ch.dir_y);
        check_field("done_res", want.done, res_ch.done_res);
        moves_checked++;
        if (res_ch.step_x || res_ch.step_y) steps_seen++;
        if (res_ch.done_res && (res_ch.step_x || res_ch.step_y)) finishes_seen++;
      end
    end
  end

  // Stimulus: directed table, then random lines with tick runs.
  initial begin
    cmd_word_t  w;
    move_word_t none;
    int         dx;
    int         dy;
    int         n;
    int         ticks;
    int         pick;
    int         span;
    none = '0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.operation = dli_pkg::OP_LOAD;
    cmd_ch.start_x = '0;
    cmd_ch.start_y = '0;
    cmd_ch.end_x = '0;
    cmd_ch.end_y = '0;
    for (int a = 0; a < 2; a++) begin
      line_pos[a] = '0;
      line_delta[a] = '0;
      line_dir[a] = 1'b0;
      line_rem[a] = '0;
      line_cnt[a] = '0;
    end
    line_mexp = 5'(dli_pkg::DEFAULT_MOD_EXP);

    // A tick before any load reports done at the origin.
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b1,
                     move_of(0, 0, 0, 0, 0, 0, 1)});
    // Full-range lines in both directions.
    plan.push_back('{cmd_of(dli_pkg::OP_LOAD, 0, 0, CMAX, CMAX), 1'b1,
                     move_of(0, 0, 0, 0, 1, 1, 0)});
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, CMAX, CMAX, CMAX, CMAX), 1'b0, none});
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b0, none});
    plan.push_back('{cmd_of(dli_pkg::OP_LOAD, CMAX, CMAX, 0, 0), 1'b1,
                     move_of(CMAX, CMAX, 0, 0, 0, 0, 0)});
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b0, none});
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b0, none});
    // Start equal to end: done at once, and a tick changes nothing.
    plan.push_back('{cmd_of(dli_pkg::OP_LOAD, 100, 200, 100, 200), 1'b1,
                     move_of(100, 200, 0, 0, 0, 0, 1)});
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b1,
                     move_of(100, 200, 0, 0, 0, 0, 1)});
    // Unit move on x with the default modulus, ticked past its end.
    plan.push_back('{cmd_of(dli_pkg::OP_LOAD, 5, 5, 6, 5), 1'b1,
                     move_of(5, 5, 0, 0, 1, 0, 0)});
    for (int i = 0; i < 4; i++) begin
      plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b0, none});
    end
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b1,
                     move_of(6, 5, 0, 0, 1, 0, 1)});
    // Short line down in x and up in y from the edge of the field.
    plan.push_back('{cmd_of(dli_pkg::OP_LOAD, CMAX, 0, CMAX - 3, 1), 1'b1,
                     move_of(CMAX, 0, 0, 0, 0, 1, 0)});
    for (int i = 0; i < 4; i++) begin
      plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b0, none});
    end
    // Alternating bit patterns.
    plan.push_back('{cmd_of(dli_pkg::OP_LOAD, 'h5555, 'h2AAA, 'h2AAA, 'h5555), 1'b1,
                     move_of('h5555, 'h2AAA, 0, 0, 0, 1, 0)});
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 'h2AAA, 'h5555, 'h5555, 'h2AAA), 1'b0,
                     none});
    plan.push_back('{cmd_of(dli_pkg::OP_TICK, 0, 0, 0, 0), 1'b0, none});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      send_word(plan[i].cmd, plan[i].typed, plan[i].want);
    end

    // Hold the sender until the directed part has fully come back.
    cmd_ch.valid <= 1'b0;
    drain_moves();

    // Random lines: mostly short ones ticked to the end, some cut short.
    while (words_sent < plan.size() + RANDOM_WORDS) begin
      no_gaps = (words_sent >= 400) && (words_sent < 500);
      w.op = dli_pkg::OP_LOAD;
      w.start_x = coord_t'($urandom_range(0, CMAX));
      w.start_y = coord_t'($urandom_range(0, CMAX));
      pick = $urandom_range(0, 99);
      span = (pick < 35) ? 40 : 6;
      if (pick < 5) begin
        w.end_x = coord_t'($urandom_range(0, CMAX));
        w.end_y = coord_t'($urandom_range(0, CMAX));
      end else begin
        w.end_x = ($urandom_range(0, 7) == 0) ? w.start_x : near_coord(w.start_x, span);
        w.end_y = ($urandom_range(0, 7) == 0) ? w.start_y : near_coord(w.start_y, span);
      end
      send_word(w, 1'b0, none);

      dx = int'(w.end_x) - int'(w.start_x);
      dy = int'(w.end_y) - int'(w.start_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      n = 1 << modulus_exp_for(coord_t'(dx > dy ? dx : dy));
      if (n > 256) ticks = $urandom_range(4, 60);
      else if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, n / 2);
      else ticks = n + $urandom_range(1, 4);

      for (int t = 0; t < ticks; t++) begin
        w.op = dli_pkg::OP_TICK;
        w.start_x = coord_t'($urandom_range(0, CMAX));
        w.start_y = coord_t'($urandom_range(0, CMAX));
        w.end_x = coord_t'($urandom_range(0, CMAX));
        w.end_y = coord_t'($urandom_range(0, CMAX));
        send_word(w, 1'b0, none);
      end

      if ($urandom_range(0, 19) == 0) begin
        cmd_ch.valid <= 1'b0;
        drain_moves();
      end
    end
    no_gaps = 1'b0;
    cmd_ch.valid <= 1'b0;

    // Let everything come back, then keep watching for stray words.
    drain_moves();
    repeat (10) @(posedge clk);

    $display("Sent %0d loads and %0d ticks; checked %0d result words.",
             loads_sent, ticks_sent, moves_checked);
    $display("Saw %0d words with an axis step and %0d lines run to their end.",
             steps_seen, finishes_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
